// ===== design/bilinear_bayer_demosaic_assert.svh =====
// assertion macros for the bilinear bayer demosaic block
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef BILINEAR_BAYER_DEMOSAIC_ASSERT_SVH
`define BILINEAR_BAYER_DEMOSAIC_ASSERT_SVH

// condition in the same cycle implies consequence in the same cycle
`define BBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define BBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bbd_pkg.sv =====
// shared types and constants of the bilinear bayer demosaic block
// no dependencies
package bbd_pkg;

    // default parameter values
    localparam int DEF_MAX_WIDTH   = 8192;
    localparam int DEF_SAMPLE_BITS = 16;

    // fixed field widths
    localparam int PIX_BITS        = 16;
    localparam int WIDTH_REG_BITS  = 14;
    localparam int HEIGHT_REG_BITS = 16;
    localparam int CFG_ADDR_BITS   = 4;
    localparam int CFG_DATA_BITS   = 16;

    // smallest usable image dimension
    localparam int MIN_DIM = 3;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_BITS'(1);

    // register reset values
    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(8192);
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(4096);

    // mosaic phase of the window center, {row odd, column odd}
    typedef enum logic [1:0] {
        PHASE_RED    = 2'b00,
        PHASE_GREEN1 = 2'b01,
        PHASE_GREEN2 = 2'b10,
        PHASE_BLUE   = 2'b11
    } phase_t;

endpackage

// ===== design/bbd_raw_if.sv =====
// raw sample stream channel with valid/ready handshake
// depends on bbd_pkg for the field width
interface bbd_raw_if;
    logic                         valid;
    logic                         ready;
    logic [bbd_pkg::PIX_BITS-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

// ===== design/bbd_rgb_if.sv =====
// rgb result stream channel with valid/ready handshake
// depends on bbd_pkg for the field widths
interface bbd_rgb_if;
    logic                         valid;
    logic                         ready;
    logic [bbd_pkg::PIX_BITS-1:0] red;
    logic [bbd_pkg::PIX_BITS-1:0] green;
    logic [bbd_pkg::PIX_BITS-1:0] blue;
    logic                         frame_last;

    modport source (output valid, output red, output green, output blue,
                    output frame_last, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_last, output ready);
endinterface

// ===== design/bbd_cfg_if.sv =====
// configuration write channel with valid/ready handshake
// depends on bbd_pkg for index and data widths
interface bbd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bbd_pkg::CFG_ADDR_BITS-1:0] reg_index;
    logic [bbd_pkg::CFG_DATA_BITS-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/bilinear_bayer_demosaic.sv =====
// Stage 1 holds the sample and its line memory read, then loads the output register.
// Throughput: one sample per cycle unless stalled; set by the line memory, read
// at the new column while the previous column is written back, one port of each kind.
// Reset clears the counters, window and both valid flags and loads the config reset
// values at once; the line memory is not cleared and has no clearing pass.
// Depends on bbd_pkg, the three channel interfaces and the assertion header.
`include "bilinear_bayer_demosaic_assert.svh"

module bilinear_bayer_demosaic #(
    parameter int MAX_WIDTH   = bbd_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = bbd_pkg::DEF_SAMPLE_BITS
) (
    input  logic  clk,
    input  logic  rst_n,
    bbd_cfg_if.sink   cfg,
    bbd_raw_if.sink   raw,
    bbd_rgb_if.source rgb
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > bbd_pkg::WIDTH_REG_BITS) ? CW + 1 : bbd_pkg::WIDTH_REG_BITS;
    localparam int HB = bbd_pkg::HEIGHT_REG_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int MB = 2 * SAMPLE_BITS;

    // configuration registers
    logic [bbd_pkg::WIDTH_REG_BITS-1:0] width_reg;
    logic [HB-1:0]                      height_reg;

    // position counters
    logic [CW-1:0] col_reg, col_next;
    logic [HB-1:0] row_reg, row_next;

    // stage 1: sample waiting for its line memory data
    logic                  s1_valid_reg, s1_valid_next;
    logic [SB-1:0]         s1_sample_reg;
    logic [CW-1:0]         s1_col_reg;
    logic                  s1_produce_reg;
    logic                  s1_last_reg;
    bbd_pkg::phase_t       s1_phase_reg;

    // line memory, entry holds {two rows up, one row up}
    logic [MB-1:0] line_mem [MAX_WIDTH];
    logic [MB-1:0] rd_data_reg;

    // window columns x=0 and x=1 of rows 0..2
    logic [SB-1:0] win_reg [3][2];

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [bbd_pkg::PIX_BITS-1:0] red_reg, green_reg, blue_reg;
    logic                         last_reg;

    logic          in_fire;
    logic          s1_adv;
    logic [EW-1:0] eff_w;
    logic [EW-1:0] col_plus;
    logic [HB-1:0] eff_h;
    logic [HB:0]   row_plus;
    logic          col_wrap;
    logic          last_now;
    logic [SB-1:0] up1;
    logic [SB-1:0] up2;
    logic [SB+1:0] edge_sum;
    logic [SB+1:0] diag_sum;
    logic [SB:0]   horiz_sum;
    logic [SB:0]   vert_sum;
    logic [SB-1:0] red_val, green_val, blue_val;

    // handshakes
    assign in_fire   = raw.valid && raw.ready;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rgb.ready);
    assign raw.ready = !s1_valid_reg || s1_adv;
    assign cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bbd_pkg::WIDTH_RESET;
            height_reg <= bbd_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.reg_index)
                bbd_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg.wdata[bbd_pkg::WIDTH_REG_BITS-1:0];
                bbd_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg.wdata[HB-1:0];
                default:
                    ;
            endcase
        end
    end

    // effective image size
    always_comb
    begin
        if (EW'(width_reg) < EW'(bbd_pkg::MIN_DIM))
            eff_w = EW'(bbd_pkg::MIN_DIM);
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(width_reg);
        eff_h = (height_reg < HB'(bbd_pkg::MIN_DIM)) ? HB'(bbd_pkg::MIN_DIM) : height_reg;
    end

    // counter advance
    always_comb
    begin
        col_plus = EW'(col_reg) + EW'(1);
        row_plus = {1'b0, row_reg} + (HB + 1)'(1);
        col_wrap = col_plus >= eff_w;
        last_now = (col_plus == eff_w) && (row_plus == {1'b0, eff_h});
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = (row_plus >= {1'b0, eff_h}) ? '0 : row_plus[HB-1:0];
            end
            else
            begin
                col_next = col_plus[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1 control
    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg  <= raw.raw_sample[SB-1:0];
            s1_col_reg     <= col_reg;
            s1_produce_reg <= (row_reg >= HB'(2)) && (col_reg >= CW'(2));
            s1_last_reg    <= last_now;
            s1_phase_reg   <= bbd_pkg::phase_t'({~row_reg[0], ~col_reg[0]});
        end
    end

    // line memory: read the new column, write back the column leaving stage 1
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_col_reg] <= {up1, s1_sample_reg};
        if (in_fire)
            rd_data_reg <= line_mem[col_reg];
    end

    assign up1 = rd_data_reg[SB-1:0];
    assign up2 = rd_data_reg[MB-1:SB];

    // window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int y = 0; y < 3; y++)
            begin
                win_reg[y][0] <= '0;
                win_reg[y][1] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int y = 0; y < 3; y++)
                win_reg[y][0] <= win_reg[y][1];
            win_reg[0][1] <= up2;
            win_reg[1][1] <= up1;
            win_reg[2][1] <= s1_sample_reg;
        end
    end

    // interpolation over the window and the incoming column
    always_comb
    begin
        edge_sum  = (SB + 2)'(win_reg[0][1]) + (SB + 2)'(win_reg[2][1])
                  + (SB + 2)'(win_reg[1][0]) + (SB + 2)'(up1);
        diag_sum  = (SB + 2)'(win_reg[0][0]) + (SB + 2)'(up2)
                  + (SB + 2)'(win_reg[2][0]) + (SB + 2)'(s1_sample_reg);
        horiz_sum = (SB + 1)'(win_reg[1][0]) + (SB + 1)'(up1);
        vert_sum  = (SB + 1)'(win_reg[0][1]) + (SB + 1)'(win_reg[2][1]);
        case (s1_phase_reg)
            bbd_pkg::PHASE_RED:
            begin
                red_val   = win_reg[1][1];
                green_val = edge_sum[SB+1:2];
                blue_val  = diag_sum[SB+1:2];
            end
            bbd_pkg::PHASE_GREEN1:
            begin
                red_val   = horiz_sum[SB:1];
                green_val = win_reg[1][1];
                blue_val  = vert_sum[SB:1];
            end
            bbd_pkg::PHASE_GREEN2:
            begin
                red_val   = vert_sum[SB:1];
                green_val = win_reg[1][1];
                blue_val  = horiz_sum[SB:1];
            end
            default:
            begin
                red_val   = diag_sum[SB+1:2];
                green_val = edge_sum[SB+1:2];
                blue_val  = win_reg[1][1];
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_produce_reg)
            out_valid_next = 1'b1;
        else if (rgb.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_produce_reg)
        begin
            red_reg   <= bbd_pkg::PIX_BITS'(red_val);
            green_reg <= bbd_pkg::PIX_BITS'(green_val);
            blue_reg  <= bbd_pkg::PIX_BITS'(blue_val);
            last_reg  <= s1_last_reg;
        end
    end

    assign rgb.valid      = out_valid_reg;
    assign rgb.red        = red_reg;
    assign rgb.green      = green_reg;
    assign rgb.blue       = blue_reg;
    assign rgb.frame_last = last_reg;

    // checks
    `BBD_ASSERT_IMP(a_no_same_entry, s1_adv && in_fire, s1_col_reg != col_reg,
        "line memory read and write hit the same entry")
    `BBD_ASSERT_NEXT(a_hold_read_data, s1_valid_reg && !s1_adv, $stable(rd_data_reg),
        "line memory read data changed while stage 1 stalled")
    `BBD_ASSERT_NEXT(a_result_loaded, s1_adv && s1_produce_reg, out_valid_reg,
        "interior pixel left stage 1 without a result")
    `BBD_ASSERT_NEXT(a_last_wraps, in_fire && last_now, col_reg == '0 && row_reg == '0,
        "frame end did not wrap the counters")

endmodule
